// ----- design/cie_pkg.sv -----
// shared constants and types of the execute core
// no dependencies; imported by the divider, datapath, controller, top module and testbench
package cie_pkg;

  localparam int MEM_WORDS = 256;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int XLEN      = 32;
  localparam int NREGS     = 16;
  localparam int PC_W      = 12;

  // flag bit positions
  localparam int FL_OV = 0;
  localparam int FL_Z  = 1;
  localparam int FL_N  = 2;
  localparam int FL_NZ = 3;
  localparam int FL_T  = 4;
  localparam int FL_C  = 5;

  typedef struct packed {
    logic accept;
    logic decode;
    logic rd1;
    logic rd2;
    logic div_start;
    logic load_issue;
    logic commit;
    logic clear;
  } cie_cmd_t;

  typedef struct packed {
    logic fetch_go;
    logic clear_done;
    logic is_div;
    logic is_load;
    logic div_done;
  } cie_sts_t;

  typedef struct packed {
    logic [PC_W-1:0] next_pc;
    logic            halted;
    logic [31:0]     instruction_word;
    logic            reg_written;
    logic [3:0]      reg_index;
    logic [31:0]     reg_value;
    logic            mem_written;
    logic [7:0]      mem_address;
    logic [31:0]     mem_value;
    logic [5:0]      flag_bits;
  } cie_res_t;

endpackage

// ----- design/cie_in_if.sv -----
// input channel of the execute core: valid/ready plus one item
// depends on nothing
interface cie_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [7:0]         load_address;
  logic signed [31:0] load_word;

  modport source(output valid, op, load_address, load_word, input ready);
  modport sink(input valid, op, load_address, load_word, output ready);
endinterface

// ----- design/cie_out_if.sv -----
// result channel of the execute core: valid/ready plus one result item
// depends on nothing
interface cie_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        next_pc;
  logic               halted;
  logic [31:0]        instruction_word;
  logic               reg_written;
  logic [3:0]         reg_index;
  logic signed [31:0] reg_value;
  logic               mem_written;
  logic [7:0]         mem_address;
  logic signed [31:0] mem_value;
  logic [5:0]         flag_bits;

  modport source(output valid, next_pc, halted, instruction_word, reg_written, reg_index,
                 reg_value, mem_written, mem_address, mem_value, flag_bits, input ready);
  modport sink(input valid, next_pc, halted, instruction_word, reg_written, reg_index,
               reg_value, mem_written, mem_address, mem_value, flag_bits, output ready);
endinterface

// ----- design/cie_ram.sv -----
// generic single-write, single-read ram with registered read data
// depends on nothing
module cie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- design/cie_div.sv -----
// iterative 32-bit divider, one quotient bit per cycle, signed or unsigned
// depends on cie_pkg
module cie_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     sgn,
  input  logic [cie_pkg::XLEN-1:0] a,
  input  logic [cie_pkg::XLEN-1:0] b,
  output logic                     done,
  output logic [cie_pkg::XLEN-1:0] q
);
  import cie_pkg::*;

  localparam int CW = $clog2(XLEN);

  logic            busy_r, done_r, neg_r;
  logic [CW-1:0]   cnt_r;
  logic [XLEN-1:0] q_r, b_r, rem_r;
  logic [XLEN:0]   trial;

  assign trial = {rem_r, q_r[XLEN-1]} - {1'b0, b_r};
  assign done  = done_r;
  assign q     = neg_r ? (~q_r + 1'b1) : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      cnt_r <= '0;
      if (b == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(XLEN - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      if (b == '0) begin
        // divide by zero reads as all ones
        q_r   <= '1;
        neg_r <= 1'b0;
      end else begin
        neg_r <= sgn & (a[XLEN-1] ^ b[XLEN-1]);
        q_r   <= (sgn & a[XLEN-1]) ? (~a + 1'b1) : a;
        b_r   <= (sgn & b[XLEN-1]) ? (~b + 1'b1) : b;
      end
    end else if (busy_r) begin
      if (!trial[XLEN]) begin
        rem_r <= trial[XLEN-1:0];
        q_r   <= {q_r[XLEN-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[XLEN-2:0], q_r[XLEN-1]};
        q_r   <= {q_r[XLEN-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- design/cie_dp.sv -----
// datapath: pc, flags, halt latch, register file and word memory, alu, result register
// depends on cie_pkg, cie_ram, cie_div
module cie_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  cie_pkg::cie_cmd_t cmd,
  output cie_pkg::cie_sts_t st,
  input  logic              in_op,
  input  logic [7:0]        in_load_address,
  input  logic [31:0]       in_load_word,
  output cie_pkg::cie_res_t res
);
  import cie_pkg::*;

  localparam logic [1:0] LY_ALU   = 2'd0;
  localparam logic [1:0] LY_CONST = 2'd1;
  localparam logic [1:0] LY_MEM   = 2'd2;
  localparam logic [1:0] LY_JUMP  = 2'd3;

  localparam logic [5:0] AL_ADD    = 6'd0;
  localparam logic [5:0] AL_ADDU   = 6'd1;
  localparam logic [5:0] AL_ADDI   = 6'd2;
  localparam logic [5:0] AL_INC    = 6'd3;
  localparam logic [5:0] AL_SUB    = 6'd4;
  localparam logic [5:0] AL_SUBD   = 6'd5;
  localparam logic [5:0] AL_DEC    = 6'd6;
  localparam logic [5:0] AL_SUBU   = 6'd7;
  localparam logic [5:0] AL_ADDIU  = 6'd8;
  localparam logic [5:0] AL_PASSB  = 6'd9;
  localparam logic [5:0] AL_PASSNB = 6'd10;
  localparam logic [5:0] AL_SDIV   = 6'd11;
  localparam logic [5:0] AL_UDIV   = 6'd12;
  localparam logic [5:0] AL_SHLS   = 6'd13;
  localparam logic [5:0] AL_ASR    = 6'd14;
  localparam logic [5:0] AL_ZERO   = 6'd15;
  localparam logic [5:0] AL_ONE    = 6'd16;
  localparam logic [5:0] AL_MOVA   = 6'd17;
  localparam logic [5:0] AL_NOTA   = 6'd18;
  localparam logic [5:0] AL_AND    = 6'd19;
  localparam logic [5:0] AL_ANDN   = 6'd20;
  localparam logic [5:0] AL_NAND   = 6'd21;
  localparam logic [5:0] AL_OR     = 6'd22;
  localparam logic [5:0] AL_ORN    = 6'd23;
  localparam logic [5:0] AL_NOR    = 6'd24;
  localparam logic [5:0] AL_XOR    = 6'd25;
  localparam logic [5:0] AL_XORN   = 6'd26;
  localparam logic [5:0] AL_XNOR   = 6'd27;
  localparam logic [5:0] AL_SHL    = 6'd28;
  localparam logic [5:0] AL_SHR    = 6'd29;
  localparam logic [5:0] AL_SLT    = 6'd30;
  localparam logic [5:0] AL_SLTU   = 6'd31;

  localparam logic [1:0] CK_SEXT = 2'd0;
  localparam logic [1:0] CK_LO   = 2'd1;
  localparam logic [1:0] CK_HI   = 2'd2;

  localparam logic [1:0] MO_LD = 2'd0;
  localparam logic [1:0] MO_ST = 2'd1;

  localparam logic [3:0] JO_JMP  = 4'd0;
  localparam logic [3:0] JO_JT   = 4'd1;
  localparam logic [3:0] JO_JF   = 4'd2;
  localparam logic [3:0] JO_LINK = 4'd3;
  localparam logic [3:0] JO_JR   = 4'd4;

  localparam logic [3:0] CC_FIRST = 4'd1;
  localparam logic [3:0] CC_LAST  = 4'd6;
  localparam logic [3:0] LINK_REG = 4'd7;
  localparam logic [31:0] ONES    = 32'hFFFF_FFFF;

  // returns {bad, overflow, carry}
  function automatic logic [2:0] add_chk(input logic [31:0] x, input logic [31:0] y,
                                         input logic uns);
    logic [32:0] s;
    logic        ov;
    s  = {1'b0, x} + {1'b0, y};
    ov = ~(x[31] ^ y[31]) & (x[31] ^ s[31]);
    return {uns ? s[32] : ov, ~uns & ov, s[32]};
  endfunction

  function automatic logic [3:0] nzt(input logic [31:0] r);
    logic z;
    z = (r == '0);
    return {~z, z | r[31], r[31], z};
  endfunction

  function automatic logic [5:0] fin(input logic [2:0] k, input logic [31:0] r);
    return {k[0], (k[2] ? 4'b0000 : nzt(r)), k[1]};
  endfunction

  logic [PC_W-1:0]   pc_r, fpc_r;
  logic              halt_r;
  logic [5:0]        flags_r;
  logic [MEM_AW-1:0] clr_r;
  logic [31:0]       ir_r, a_r, b_r;

  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata, mem_rdata;
  logic              rf_we, rf_re;
  logic [3:0]        rf_waddr, rf_raddr;
  logic [31:0]       rf_wdata, rf_rdata;

  logic [31:0]       div_q;
  logic              div_done;

  logic [1:0]        lay;
  logic [5:0]        aopc;
  logic [3:0]        fd, fs, jcond, cmi;
  logic [1:0]        copc, mopc;
  logic [3:0]        jopc;
  logic [15:0]       kval;
  logic [11:0]       target;
  logic              cond_f;

  logic [31:0]       alu_r, nb, s_ab, d_ab;
  logic [5:0]        alu_f;
  logic              alu_w;
  logic [2:0]        k1;

  logic              c_rw, c_mw, c_halt;
  logic [3:0]        c_ri;
  logic [31:0]       c_rv, c_mv;
  logic [7:0]        c_ma;
  logic [5:0]        c_f;
  logic [PC_W-1:0]   c_pc;

  cie_ram #(.WIDTH(XLEN), .DEPTH(MEM_WORDS)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  cie_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf (
    .clk  (clk),
    .we   (rf_we),
    .waddr(rf_waddr),
    .wdata(rf_wdata),
    .re   (rf_re),
    .raddr(rf_raddr),
    .rdata(rf_rdata)
  );

  cie_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .sgn  (aopc == AL_SDIV),
    .a    (a_r),
    .b    (b_r),
    .done (div_done),
    .q    (div_q)
  );

  assign lay    = ir_r[31:30];
  assign aopc   = ir_r[17:12];
  assign fd     = ir_r[11:8];
  assign fs     = ir_r[7:4];
  assign copc   = ir_r[21:20];
  assign kval   = ir_r[15:0];
  assign mopc   = ir_r[9:8];
  assign jopc   = ir_r[23:20];
  assign jcond  = ir_r[19:16];
  assign target = ir_r[11:0];
  assign cmi    = jcond - CC_FIRST;
  assign cond_f = (jcond >= CC_FIRST) && (jcond <= CC_LAST) && flags_r[cmi[2:0]];

  assign st.fetch_go   = in_op & ~halt_r;
  assign st.clear_done = (clr_r == MEM_AW'(MEM_WORDS - 1));
  assign st.is_div     = (lay == LY_ALU) && ((aopc == AL_SDIV) || (aopc == AL_UDIV));
  assign st.is_load    = (lay == LY_MEM) && (mopc == MO_LD);
  assign st.div_done   = div_done;

  // memory ports: clearing pass, op 0 writes and stores share the write port
  always_comb begin
    mem_we    = cmd.clear | (cmd.accept & ~in_op) | (cmd.commit & c_mw);
    mem_waddr = a_r[MEM_AW-1:0];
    mem_wdata = b_r;
    if (cmd.clear) begin
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (cmd.accept) begin
      mem_waddr = MEM_AW'(in_load_address);
      mem_wdata = in_load_word;
    end
    mem_re    = cmd.accept | cmd.load_issue;
    mem_raddr = cmd.accept ? MEM_AW'(pc_r) : a_r[MEM_AW-1:0];
  end

  // register file: first read picks its index from the freshly fetched word
  always_comb begin
    rf_we    = cmd.clear | (cmd.commit & c_rw);
    rf_waddr = cmd.clear ? clr_r[3:0] : c_ri;
    rf_wdata = cmd.clear ? '0 : c_rv;
    rf_re    = cmd.decode | cmd.rd1;
    rf_raddr = ir_r[3:0];
    if (cmd.decode) begin
      unique case (mem_rdata[31:30])
        LY_ALU:   rf_raddr = mem_rdata[7:4];
        LY_CONST: rf_raddr = mem_rdata[19:16];
        LY_MEM:   rf_raddr = (mem_rdata[9:8] == MO_LD) ? mem_rdata[3:0] : mem_rdata[7:4];
        LY_JUMP:  rf_raddr = mem_rdata[15:12];
        default:  rf_raddr = mem_rdata[7:4];
      endcase
    end
  end

  always_comb begin
    nb    = ~b_r + 32'd1;
    s_ab  = a_r + b_r;
    d_ab  = a_r - b_r;
    alu_r = '0;
    alu_f = flags_r;
    alu_w = 1'b1;
    k1    = '0;
    unique case (aopc)
      AL_ADD: begin
        k1 = add_chk(a_r, b_r, 1'b0); alu_r = s_ab; alu_f = fin(k1, alu_r);
      end
      AL_ADDU: begin
        k1 = add_chk(a_r, b_r, 1'b1); alu_r = s_ab; alu_f = fin(k1, alu_r);
      end
      AL_ADDI, AL_ADDIU: begin
        k1    = add_chk(a_r, b_r, aopc == AL_ADDIU);
        alu_r = s_ab;
        if (!k1[2]) begin
          alu_r = s_ab + 32'd1;
          k1    = add_chk(s_ab + 32'd1, 32'd1, aopc == AL_ADDIU);
        end
        alu_f = fin(k1, alu_r);
      end
      AL_INC: begin
        k1 = add_chk(a_r, 32'd1, 1'b0); alu_r = a_r + 32'd1; alu_f = fin(k1, alu_r);
      end
      AL_SUB: begin
        k1 = add_chk(a_r, nb, 1'b0); alu_r = d_ab; alu_f = fin(k1, alu_r);
      end
      AL_SUBD: begin
        k1    = add_chk(a_r, nb, 1'b0);
        alu_r = d_ab - 32'd1;
        if (!k1[2]) begin
          k1 = add_chk(d_ab, ONES, 1'b0);
        end
        alu_f = fin(k1, alu_r);
      end
      AL_DEC: begin
        k1 = add_chk(a_r, ONES, 1'b0); alu_r = a_r - 32'd1; alu_f = fin(k1, alu_r);
      end
      AL_SUBU: begin
        k1 = add_chk(a_r, nb, 1'b1); alu_r = d_ab; alu_f = fin(k1, alu_r);
      end
      AL_PASSB:  alu_r = a_r;
      AL_PASSNB: alu_r = ~a_r;
      AL_SDIV, AL_UDIV: begin
        alu_r = div_q; alu_f = fin(3'b000, alu_r);
      end
      AL_SHLS: begin
        k1    = {a_r[31] | (a_r[31] ^ a_r[30]), a_r[31] ^ a_r[30], a_r[31]};
        alu_r = {a_r[30:0], 1'b0};
        alu_f = fin(k1, alu_r);
      end
      AL_ASR:  begin alu_r = {a_r[31], a_r[31:1]}; alu_f = fin(3'b000, alu_r); end
      AL_ZERO: begin alu_r = '0;                   alu_f = fin(3'b000, alu_r); end
      AL_ONE:  begin alu_r = 32'd1;                alu_f = fin(3'b000, alu_r); end
      AL_MOVA: begin alu_r = a_r;                  alu_f = fin(3'b000, alu_r); end
      AL_NOTA: begin alu_r = ~a_r;                 alu_f = fin(3'b000, alu_r); end
      AL_AND:  begin alu_r = a_r & b_r;            alu_f = fin(3'b000, alu_r); end
      AL_ANDN: begin alu_r = ~a_r & b_r;           alu_f = fin(3'b000, alu_r); end
      AL_NAND: begin alu_r = ~(a_r & b_r);         alu_f = fin(3'b000, alu_r); end
      AL_OR:   begin alu_r = a_r | b_r;            alu_f = fin(3'b000, alu_r); end
      AL_ORN:  begin alu_r = ~a_r | b_r;           alu_f = fin(3'b000, alu_r); end
      AL_NOR:  begin alu_r = ~(a_r | b_r);         alu_f = fin(3'b000, alu_r); end
      AL_XOR:  begin alu_r = a_r ^ b_r;            alu_f = fin(3'b000, alu_r); end
      AL_XORN: begin alu_r = ~a_r ^ b_r;           alu_f = fin(3'b000, alu_r); end
      AL_XNOR: begin alu_r = ~(a_r ^ b_r);         alu_f = fin(3'b000, alu_r); end
      AL_SHL: begin
        k1    = {a_r[31], 1'b0, a_r[31]};
        alu_r = {a_r[30:0], 1'b0};
        alu_f = fin(k1, alu_r);
      end
      AL_SHR: begin alu_r = {1'b0, a_r[31:1]}; alu_f = fin(3'b000, alu_r); end
      AL_SLT: begin
        alu_r = {31'd0, $signed(a_r) < $signed(b_r)}; alu_f = fin(3'b000, alu_r);
      end
      AL_SLTU: begin alu_r = {31'd0, a_r < b_r}; alu_f = fin(3'b000, alu_r); end
      default: alu_w = 1'b0;
    endcase
  end

  always_comb begin
    c_rw   = 1'b0;
    c_ri   = '0;
    c_rv   = '0;
    c_mw   = 1'b0;
    c_ma   = '0;
    c_mv   = '0;
    c_f    = flags_r;
    c_pc   = pc_r;
    c_halt = halt_r;
    unique case (lay)
      LY_ALU: begin
        // a move onto itself is a no-op
        if (alu_w && !(aopc == AL_MOVA && fd == fs)) begin
          c_rw = 1'b1; c_ri = fd; c_rv = alu_r; c_f = alu_f;
        end
      end
      LY_CONST: begin
        c_ri = ir_r[19:16];
        c_rw = 1'b1;
        unique case (copc)
          CK_SEXT: c_rv = {{16{kval[15]}}, kval};
          CK_LO:   c_rv = {a_r[31:16], kval};
          CK_HI:   c_rv = {kval, a_r[15:0]};
          default: begin c_rw = 1'b0; c_ri = '0; end
        endcase
      end
      LY_MEM: begin
        if (mopc == MO_LD) begin
          c_rw = 1'b1; c_ri = ir_r[7:4]; c_rv = mem_rdata;
        end else if (mopc == MO_ST) begin
          c_mw = 1'b1; c_ma = 8'(a_r[MEM_AW-1:0]); c_mv = b_r;
        end
      end
      LY_JUMP: begin
        unique case (jopc)
          JO_JMP: begin
            c_pc = target;
            if (target == fpc_r) begin
              c_halt = 1'b1;
            end
          end
          JO_JT: if (cond_f) c_pc = target;
          JO_JF: if (!cond_f) c_pc = target;
          JO_LINK: begin
            // the link register is written first, so linking through it keeps the pc
            c_rw = 1'b1; c_ri = LINK_REG; c_rv = 32'(pc_r);
            c_pc = (ir_r[15:12] == LINK_REG) ? pc_r : a_r[PC_W-1:0];
          end
          JO_JR:   c_pc = a_r[PC_W-1:0];
          default: c_pc = pc_r;
        endcase
      end
      default: c_pc = pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      halt_r  <= 1'b0;
      flags_r <= '0;
      clr_r   <= '0;
    end else begin
      if (cmd.clear) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.decode) begin
        pc_r <= pc_r + 1'b1;
      end
      if (cmd.commit) begin
        pc_r    <= c_pc;
        halt_r  <= c_halt;
        flags_r <= c_f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      fpc_r <= pc_r;
      if (!st.fetch_go) begin
        res <= '{next_pc: pc_r, halted: halt_r, flag_bits: flags_r, default: '0};
      end
    end
    if (cmd.decode) begin
      ir_r <= mem_rdata;
    end
    if (cmd.rd1) begin
      a_r <= rf_rdata;
    end
    if (cmd.rd2) begin
      b_r <= rf_rdata;
    end
    if (cmd.commit) begin
      res <= '{next_pc: c_pc, halted: c_halt, instruction_word: ir_r, reg_written: c_rw,
               reg_index: c_ri, reg_value: c_rv, mem_written: c_mw, mem_address: c_ma,
               mem_value: c_mv, flag_bits: c_f};
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n) halt_r |=> halt_r)
    else $error("halt latch dropped");
  a_div_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_start && b_r != '0) |=> !div_done)
    else $error("divider done not cleared on start");
  a_no_store_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && st.is_load) |-> !c_mw)
    else $error("load also stored");

endmodule

// ----- design/cie_ctrl.sv -----
// controller state machine: clearing pass, fetch, register reads, execute, divide wait, load, result hold
// depends on cie_pkg
module cie_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cie_pkg::cie_sts_t st,
  output cie_pkg::cie_cmd_t cmd
);
  import cie_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_FETCH = 9'b000000100,
    S_RD1   = 9'b000001000,
    S_RD2   = 9'b000010000,
    S_EXEC  = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_LOAD  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = st.fetch_go ? S_FETCH : S_DONE;
        end
      end
      S_FETCH: begin
        cmd.decode = 1'b1;
        state_nxt  = S_RD1;
      end
      S_RD1: begin
        cmd.rd1   = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.rd2   = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        priority if (st.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (st.is_load) begin
          cmd.load_issue = 1'b1;
          state_nxt      = S_LOAD;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_LOAD: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == S_DONE)
    else $error("commit not followed by result");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !st.div_done) |=> state_r == S_DIV)
    else $error("left divide wait early");
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input taken while result pending");

endmodule

// ----- design/custom_isa_execute_core_unit.sv -----
// Execute core with 16 registers, six flags, a 12-bit pc and a 256-word memory. After reset
// the block runs a clearing pass over the memory before taking the first item. It works on
// one item at a time: an op 0 item or a step while halted goes from acceptance straight to
// the result; an executed instruction passes fetch, two register file reads through its
// single read port, execute and result, a load adds a memory read, and a divide waits on
// the divider, which makes one quotient bit per cycle. The next item is taken once the result is gone.
// depends on cie_pkg, cie_in_if, cie_out_if, cie_dp, cie_ctrl
module custom_isa_execute_core_unit (
  input logic      clk,
  input logic      rst_n,
  cie_in_if.sink   in_ch,
  cie_out_if.source out_ch
);
  import cie_pkg::*;

  cie_cmd_t cmd;
  cie_sts_t st;
  cie_res_t res;

  cie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  cie_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_op          (in_ch.op),
    .in_load_address(in_ch.load_address),
    .in_load_word   (in_ch.load_word),
    .res            (res)
  );

  assign out_ch.next_pc          = res.next_pc;
  assign out_ch.halted           = res.halted;
  assign out_ch.instruction_word = res.instruction_word;
  assign out_ch.reg_written      = res.reg_written;
  assign out_ch.reg_index        = res.reg_index;
  assign out_ch.reg_value        = res.reg_value;
  assign out_ch.mem_written      = res.mem_written;
  assign out_ch.mem_address      = res.mem_address;
  assign out_ch.mem_value        = res.mem_value;
  assign out_ch.flag_bits        = res.flag_bits;

endmodule

// ----- test/custom_isa_execute_core_unit_tb.sv -----
// testbench of the execute core: random and directed programs checked against a predictor
// depends on cie_pkg, cie_in_if, cie_out_if and custom_isa_execute_core_unit
module custom_isa_execute_core_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cie_pkg::*;

  typedef enum bit [1:0] {L_ALU, L_CONST, L_MEM, L_JUMP} layout_e;
  typedef enum bit [5:0] {
    A_ADD, A_ADDU, A_ADDINC, A_INC, A_SUB, A_SUBDEC, A_DEC, A_SUBU,
    A_ADDINCU, A_MOVQ, A_NOTQ, A_SDIV, A_UDIV, A_SHLV, A_ASR, A_CLR,
    A_ONE, A_MOV, A_NOT, A_AND, A_ANDN, A_NAND, A_OR, A_ORN,
    A_NOR, A_XOR, A_XNORA, A_XNOR, A_SHL, A_LSR, A_SLT, A_SLTU
  } alu_op_e;
  typedef enum bit [1:0] {K_SEXT, K_LOW, K_HIGH, K_NONE} const_op_e;
  typedef enum bit [1:0] {M_LOAD, M_STORE, M_NONE2, M_NONE3} mem_op_e;
  typedef enum bit [3:0] {J_JMP, J_IF, J_IFNOT, J_LINK, J_REG} jump_op_e;
  localparam bit OP_WRITE = 1'b0;
  localparam bit OP_STEP  = 1'b1;
  localparam int WATCHDOG = 5000;

  class exec_scoreboard;
    bit [31:0]       regs[NREGS];
    bit [31:0]       mem[MEM_WORDS];
    bit [5:0]        flags;
    bit [PC_W-1:0]   pc;
    bit              halt;
    cie_res_t        pending[$];
    int              errors, checked, steps;

    function bit add_chk(bit [31:0] a, bit [31:0] b, bit uns);
      bit [31:0] s;
      s = a + b;
      flags[FL_OV] = 0;
      flags[FL_C] = s < a;
      if (uns) return flags[FL_C];
      if ((~(a ^ b) & (a ^ s)) >> 31) begin
        flags[FL_OV] = 1;
        return 1;
      end
      return 0;
    endfunction

    function void set_nzt(bit [31:0] r);
      flags[FL_Z] = r == 0;
      flags[FL_NZ] = r == 0 || r[31];
      flags[FL_N] = r[31];
      flags[FL_T] = r != 0;
    endfunction

    function void settle(bit bad, bit [31:0] r);
      if (bad) begin
        flags[FL_Z] = 0; flags[FL_N] = 0; flags[FL_NZ] = 0; flags[FL_T] = 0;
      end else begin
        set_nzt(r);
      end
    endfunction

    function void plain(bit [31:0] r);
      flags[FL_OV] = 0;
      flags[FL_C] = 0;
      set_nzt(r);
    endfunction

    function bit [31:0] sdiv(bit [31:0] a, bit [31:0] b);
      bit [31:0] ua, ub, q;
      if (b == 0) return '1;
      if (a == 32'h8000_0000 && b == '1) return a;
      ua = a[31] ? -a : a;
      ub = b[31] ? -b : b;
      q = ua / ub;
      return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function bit alu(bit [5:0] opc, bit [31:0] a, bit [31:0] b, output bit [31:0] r);
      bit bad;
      r = 0;
      case (opc)
        A_ADD: begin bad = add_chk(a, b, 0); r = a + b; settle(bad, r); end
        A_ADDU: begin bad = add_chk(a, b, 1); r = a + b; settle(bad, r); end
        A_ADDINC: begin
          bad = add_chk(a, b, 0); r = a + b;
          if (!bad) begin r = r + 1; bad = add_chk(r, 1, 0); end
          settle(bad, r);
        end
        A_INC: begin bad = add_chk(a, 1, 0); r = a + 1; settle(bad, r); end
        A_SUB: begin bad = add_chk(a, -b, 0); r = a - b; settle(bad, r); end
        A_SUBDEC: begin
          bad = add_chk(a, -b, 0); r = a - b - 1;
          if (!bad) bad = add_chk(a - b, '1, 0);
          settle(bad, r);
        end
        A_DEC: begin bad = add_chk(a, '1, 0); r = a - 1; settle(bad, r); end
        A_SUBU: begin bad = add_chk(a, -b, 1); r = a - b; settle(bad, r); end
        A_ADDINCU: begin
          bad = add_chk(a, b, 1); r = a + b;
          if (!bad) begin r = r + 1; bad = add_chk(r, 1, 1); end
          settle(bad, r);
        end
        A_MOVQ: r = a;
        A_NOTQ: r = ~a;
        A_SDIV: begin r = sdiv(a, b); plain(r); end
        A_UDIV: begin r = (b == 0) ? '1 : a / b; plain(r); end
        A_SHLV: begin
          flags[FL_OV] = a[31] ^ a[30];
          flags[FL_C] = a[31];
          r = a << 1;
          settle(flags[FL_OV] | flags[FL_C], r);
        end
        A_ASR: begin r = {a[31], a[31:1]}; plain(r); end
        A_CLR: begin r = 0; plain(r); end
        A_ONE: begin r = 1; plain(r); end
        A_MOV: begin r = a; plain(r); end
        A_NOT: begin r = ~a; plain(r); end
        A_AND: begin r = a & b; plain(r); end
        A_ANDN: begin r = ~a & b; plain(r); end
        A_NAND: begin r = ~(a & b); plain(r); end
        A_OR: begin r = a | b; plain(r); end
        A_ORN: begin r = ~a | b; plain(r); end
        A_NOR: begin r = ~(a | b); plain(r); end
        A_XOR: begin r = a ^ b; plain(r); end
        A_XNORA: begin r = ~a ^ b; plain(r); end
        A_XNOR: begin r = ~(a ^ b); plain(r); end
        A_SHL: begin
          flags[FL_OV] = 0;
          flags[FL_C] = a[31];
          r = a << 1;
          settle(a[31], r);
        end
        A_LSR: begin r = a >> 1; plain(r); end
        A_SLT: begin r = ($signed(a) < $signed(b)) ? 1 : 0; plain(r); end
        A_SLTU: begin r = (a < b) ? 1 : 0; plain(r); end
        default: return 0;
      endcase
      return 1;
    endfunction

    // codes 1..6 pick a flag, anything else reads false
    function bit cond_true(bit [3:0] c);
      if (c == 0 || c > 6) return 0;
      return flags[c - 1];
    endfunction

    function void note_item(bit op, bit [7:0] la, bit [31:0] lw);
      cie_res_t e;
      bit [PC_W-1:0] fpc;
      bit [31:0] ir, r;
      e = '0;
      if (op == OP_WRITE) begin
        mem[la[MEM_AW-1:0]] = lw;
      end else if (!halt) begin
        steps++;
        fpc = pc;
        ir = mem[fpc[MEM_AW-1:0]];
        e.instruction_word = ir;
        pc = fpc + 1;
        case (layout_e'(ir[31:30]))
          L_ALU: begin
            if (!(ir[17:12] == A_MOV && ir[11:8] == ir[7:4]) &&
                alu(ir[17:12], regs[ir[7:4]], regs[ir[3:0]], r)) begin
              regs[ir[11:8]] = r;
              e.reg_written = 1; e.reg_index = ir[11:8]; e.reg_value = r;
            end
          end
          L_CONST: begin
            if (ir[21:20] != K_NONE) begin
              case (ir[21:20])
                K_SEXT: r = {{16{ir[15]}}, ir[15:0]};
                K_LOW: r = {regs[ir[19:16]][31:16], ir[15:0]};
                default: r = {ir[15:0], regs[ir[19:16]][15:0]};
              endcase
              regs[ir[19:16]] = r;
              e.reg_written = 1; e.reg_index = ir[19:16]; e.reg_value = r;
            end
          end
          L_MEM: begin
            if (ir[9:8] == M_LOAD) begin
              r = mem[regs[ir[3:0]][MEM_AW-1:0]];
              regs[ir[7:4]] = r;
              e.reg_written = 1; e.reg_index = ir[7:4]; e.reg_value = r;
            end else if (ir[9:8] == M_STORE) begin
              mem[regs[ir[7:4]][MEM_AW-1:0]] = regs[ir[3:0]];
              e.mem_written = 1;
              e.mem_address = regs[ir[7:4]][MEM_AW-1:0];
              e.mem_value = regs[ir[3:0]];
            end
          end
          default: begin
            case (ir[23:20])
              J_JMP: begin
                if (ir[11:0] == fpc) halt = 1;
                pc = ir[11:0];
              end
              J_IF: if (cond_true(ir[19:16])) pc = ir[11:0];
              J_IFNOT: if (!cond_true(ir[19:16])) pc = ir[11:0];
              J_LINK: begin
                regs[7] = pc;
                e.reg_written = 1; e.reg_index = 7; e.reg_value = pc;
                pc = regs[ir[15:12]][PC_W-1:0];
              end
              J_REG: pc = regs[ir[15:12]][PC_W-1:0];
              default: ;
            endcase
          end
        endcase
      end
      e.next_pc = pc;
      e.halted = halt;
      e.flag_bits = flags;
      pending.push_back(e);
    endfunction

    function void cmp(string nm, bit [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", nm, want, got);
        errors++;
      end
    endfunction

    function void check_result(cie_res_t got);
      cie_res_t e;
      if (pending.size() == 0) begin
        $error("result with no item waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      cmp("next_pc", e.next_pc, got.next_pc);
      cmp("halted", e.halted, got.halted);
      cmp("instruction_word", e.instruction_word, got.instruction_word);
      cmp("reg_written", e.reg_written, got.reg_written);
      cmp("reg_index", e.reg_index, got.reg_index);
      cmp("reg_value", e.reg_value, got.reg_value);
      cmp("mem_written", e.mem_written, got.mem_written);
      cmp("mem_address", e.mem_address, got.mem_address);
      cmp("mem_value", e.mem_value, got.mem_value);
      cmp("flag_bits", e.flag_bits, got.flag_bits);
    endfunction
  endclass

  logic clk, rst_n;
  cie_in_if in_ch();
  cie_out_if out_ch();

  custom_isa_execute_core_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  exec_scoreboard sb = new();
  int in_count, quiet_cycles, hold_cnt, items_sent;
  bit calm;

  initial clk = 0;
  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // monitors on both channels and the stall watchdog
  always @(posedge clk) begin
    cie_res_t got;
    if (rst_n) begin
      quiet_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        sb.note_item(in_ch.op, in_ch.load_address, in_ch.load_word);
        in_count++;
        quiet_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.next_pc = out_ch.next_pc;
        got.halted = out_ch.halted;
        got.instruction_word = out_ch.instruction_word;
        got.reg_written = out_ch.reg_written;
        got.reg_index = out_ch.reg_index;
        got.reg_value = out_ch.reg_value;
        got.mem_written = out_ch.mem_written;
        got.mem_address = out_ch.mem_address;
        got.mem_value = out_ch.mem_value;
        got.flag_bits = out_ch.flag_bits;
        sb.check_result(got);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side: random stalls, or a long hold-off when asked
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        out_ch.ready <= 0;
        hold_cnt--;
      end else begin
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(bit op, bit [7:0] la, bit [31:0] lw);
    int seen;
    if (!calm && $urandom_range(0, 99) < 34) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.op <= op;
    in_ch.load_address <= la;
    in_ch.load_word <= lw;
    seen = in_count;
    do @(negedge clk); while (in_count == seen);
    items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // random instruction for a given address, never an unconditional jump to itself
  function automatic bit [31:0] gen_insn(bit [7:0] place);
    bit [31:0] w;
    w = $urandom;
    case (layout_e'(w[31:30]))
      L_ALU: if ($urandom_range(0, 3) != 0) w[17:12] = 6'($urandom_range(0, 31));
      L_JUMP: begin
        w[23:20] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) :
                                                 4'($urandom_range(0, 4));
        if (w[23:20] == J_JMP && w[7:0] == place) w[0] = ~w[0];
      end
      default: ;
    endcase
    return w;
  endfunction

  bit [31:0] prog[13] = '{
    32'h4001_FFFF, 32'h4002_0000, 32'h4022_8000, 32'h4003_FFFF, 32'h4023_7FFF,
    32'h0000_0433, 32'h0000_B521, 32'h0000_C630, 32'h0001_1330, 32'h8000_0102,
    32'h8000_0080, 32'hC017_000C, 32'hC022_000E
  };

  initial begin
    bit [7:0] base;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.op = 0;
    in_ch.load_address = 0;
    in_ch.load_word = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, overflow, min/-1 divide, divide by zero, move onto itself,
    // store, load, jumps on an out-of-range and a real condition code
    foreach (prog[i]) send(OP_WRITE, 8'(i), prog[i]);
    foreach (prog[i]) send(OP_STEP, 0, 0);

    for (int ph = 0; ph < 26; ph++) begin
      calm = (ph >= 10 && ph < 13);
      if (ph == 5) hold_cnt = 300;
      if (ph % 7 == 3) drain();
      base = sb.pc[7:0];
      for (int i = 0; i < 14; i++) send(OP_WRITE, 8'(base + i), gen_insn(8'(base + i)));
      for (int i = 0; i < 4; i++) send(OP_WRITE, 8'($urandom), $urandom);
      for (int i = 0; i < 22; i++) send(OP_STEP, 8'($urandom), $urandom);
    end
    calm = 0;

    // self-jump sets the sticky halt; later steps are blocked, writes still land
    send(OP_WRITE, sb.pc[7:0], 32'hC000_0000 | sb.pc);
    repeat (3) send(OP_STEP, 0, 0);
    send(OP_WRITE, 8'($urandom), $urandom);
    send(OP_STEP, 0, 0);
    in_ch.valid <= 0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("ran %0d items, %0d executed steps, %0d results checked, halt reached: %0d",
             items_sent, sb.steps, sb.checked, sb.halt);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
